>>> design/sorted_record_table_defines.svh
// Assertion macros shared by the sorted record table design.
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srt_pkg.sv
// Types, constants and helper functions of the sorted record table.
package srt_pkg;

  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned NAME_BYTES_DEF = 25;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned NAME3_W  = 8;
  localparam int unsigned PHONE_W  = 31;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_ENTRY     = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_DUMP
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name0;
    logic [NAME_W-1:0]       name1;
    logic [NAME_W-1:0]       name2;
    logic [NAME3_W-1:0]      name3;
    logic [PHONE_W-1:0]      phone;
  } rec_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    rec_t     new_rec;
  } cell_ctrl_t;

  // Byte mask of one name word: bytes at or beyond nbytes are cleared.
  function automatic logic [NAME_W-1:0] name_mask(input int unsigned word,
                                                  input int unsigned nbytes);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int unsigned b = 0; b < NAME_W / 8; b++) begin
      if (word * (NAME_W / 8) + b < nbytes) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> design/srt_stream_if.sv
// Valid/ready channel interfaces for requests and results of the record table.
interface srt_in_if import srt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] key;
  logic [NAME_W-1:0]       name_part0;
  logic [NAME_W-1:0]       name_part1;
  logic [NAME_W-1:0]       name_part2;
  logic [NAME3_W-1:0]      name_part3;
  logic [PHONE_W-1:0]      phone;

  modport source (
    output valid, kind, key, name_part0, name_part1, name_part2, name_part3, phone,
    input  ready
  );
  modport sink (
    input  valid, kind, key, name_part0, name_part1, name_part2, name_part3, phone,
    output ready
  );
endinterface

interface srt_out_if import srt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] out_key;
  logic [NAME_W-1:0]       out_name0;
  logic [NAME_W-1:0]       out_name1;
  logic [NAME_W-1:0]       out_name2;
  logic [NAME3_W-1:0]      out_name3;
  logic [PHONE_W-1:0]      out_phone;
  logic                    last;

  modport source (
    output valid, status, out_key, out_name0, out_name1, out_name2, out_name3,
           out_phone, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_name0, out_name1, out_name2, out_name3,
           out_phone, last,
    output ready
  );
endinterface

>>> design/srt_cell.sv
// One cell of the record chain: holds one record and its compare flags.
module srt_cell import srt_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       tail_i,
  input  rec_t       left_rec_i,
  input  logic       left_le_i,
  input  rec_t       right_rec_i,
  input  rec_t       head_rec_i,
  input  logic       seen_i,
  output rec_t       rec_o,
  output logic       le_o,
  output logic       seen_o
);

  rec_t rec_q, rec_d;
  logic le_q, le_d;
  logic eq_q, eq_d;

  // A matching key here or in any cell to the left marks this cell for a left shift.
  assign seen_o = seen_i | eq_q;
  assign le_o   = le_q;
  assign rec_o  = rec_q;

  always_comb begin
    rec_d = rec_q;
    le_d  = le_q;
    eq_d  = eq_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_CMP: begin
        le_d = occ_i && ($signed(rec_q.key) <= $signed(ctrl_i.new_rec.key));
        eq_d = occ_i && (rec_q.key == ctrl_i.new_rec.key);
      end
      CELL_INS: begin
        // Keys are sorted, so the cells with le set form a prefix; the first
        // cell past it takes the new record and the rest shift right.
        if (!le_q) begin
          rec_d = left_le_i ? ctrl_i.new_rec : left_rec_i;
        end
      end
      CELL_DEL: begin
        if (seen_o) begin
          rec_d = right_rec_i;
        end
      end
      CELL_ROT: begin
        if (occ_i) begin
          rec_d = tail_i ? head_rec_i : right_rec_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    le_q  <= le_d;
    eq_q  <= eq_d;
  end

endmodule

>>> design/sorted_record_table.sv
// Sorted record table: a chain of record cells kept in ascending key order.
//
//   port    direction  transaction
//   in_i    sink       one request: insert, delete by key or dump
//   out_o   source     one result; last marks the final result of a request
//
// Insert and delete go through accept, a compare in every cell, then, where the
// request applies, a shift of the chain while the result enters the output register.
// A dump is accepted and then gives one result per stored record, the chain
// rotating one place per result; an empty table gives one result.
// A stalled output register holds the chain; a new request is taken once the
// previous request has handed its final result to the output register.
// Reset clears the record count; record contents are not reset.
`include "sorted_record_table_defines.svh"

module sorted_record_table import srt_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srt_in_if.sink    in_i,
  srt_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  kind_e             cmd_kind_q;
  rec_t              cmd_rec_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  dump_cnt_q, dump_cnt_d;
  logic [CNT_W-1:0]  count_m1;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  rec_t              out_rec_q, out_rec_d;
  logic              out_last_q, out_last_d;

  logic              in_fire;
  logic              slot_free;
  logic              load_out;
  logic              full;
  logic              found;
  logic              dump_last;
  cell_op_e          cell_op;
  cell_ctrl_t        cell_ctrl;

  rec_t              cell_rec  [DEPTH];
  rec_t              left_rec  [DEPTH];
  rec_t              right_rec [DEPTH];
  logic [DEPTH-1:0]  cell_le;
  logic [DEPTH-1:0]  left_le;
  logic [DEPTH-1:0]  seen_in;
  logic [DEPTH-1:0]  cell_seen;
  logic [DEPTH-1:0]  cell_occ;
  logic [DEPTH-1:0]  cell_tail;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || out_o.ready;
  assign count_m1  = count_q - CNT_W'(1);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign found     = cell_seen[DEPTH-1];
  assign dump_last = (dump_cnt_q == count_m1);
  assign cell_ctrl = '{op: cell_op, new_rec: cmd_rec_q};

  // Record chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i]  = (CNT_W'(i) < count_q);
    assign cell_tail[i] = (CNT_W'(i) == count_m1);

    if (i == 0) begin : g_first
      assign left_rec[i] = cmd_rec_q;
      assign left_le[i]  = 1'b1;
      assign seen_in[i]  = 1'b0;
    end else begin : g_inner
      assign left_rec[i] = cell_rec[i-1];
      assign left_le[i]  = cell_le[i-1];
      assign seen_in[i]  = cell_seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_rec[i] = cell_rec[i];
    end else begin : g_mid
      assign right_rec[i] = cell_rec[i+1];
    end

    srt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occ_i       (cell_occ[i]),
      .tail_i      (cell_tail[i]),
      .left_rec_i  (left_rec[i]),
      .left_le_i   (left_le[i]),
      .right_rec_i (right_rec[i]),
      .head_rec_i  (cell_rec[0]),
      .seen_i      (seen_in[i]),
      .rec_o       (cell_rec[i]),
      .le_o        (cell_le[i]),
      .seen_o      (cell_seen[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.kind)
            KIND_INSERT, KIND_DELETE: state_d = ST_CMP;
            KIND_DUMP:                state_d = ST_DUMP;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CMP: state_d = ST_APPLY;
      ST_APPLY: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (slot_free && ((count_q == '0) || dump_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chain control, count update and result formation
  always_comb begin
    cell_op      = CELL_HOLD;
    load_out     = 1'b0;
    out_status_d = STATUS_DONE;
    out_rec_d    = '0;
    out_last_d   = 1'b1;
    count_d      = count_q;
    dump_cnt_d   = in_fire ? '0 : dump_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_CMP: cell_op = CELL_CMP;
      ST_APPLY: begin
        if (slot_free) begin
          load_out = 1'b1;
          unique case (cmd_kind_q)
            KIND_INSERT: begin
              if (full) begin
                out_status_d = STATUS_FULL;
              end else begin
                cell_op = CELL_INS;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_DELETE: begin
              if (found) begin
                cell_op = CELL_DEL;
                count_d = count_m1;
              end else begin
                out_status_d = STATUS_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (count_q == '0) begin
            out_status_d = STATUS_EMPTY;
          end else begin
            out_status_d = STATUS_ENTRY;
            out_rec_d    = cell_rec[0];
            out_last_d   = dump_last;
            cell_op      = CELL_ROT;
            dump_cnt_d   = dump_cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_cnt_q  <= dump_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_kind_q      <= kind_e'(in_i.kind);
      cmd_rec_q.key   <= in_i.key;
      cmd_rec_q.name0 <= in_i.name_part0 & name_mask(0, NAME_BYTES);
      cmd_rec_q.name1 <= in_i.name_part1 & name_mask(1, NAME_BYTES);
      cmd_rec_q.name2 <= in_i.name_part2 & name_mask(2, NAME_BYTES);
      cmd_rec_q.name3 <= in_i.name_part3 & NAME3_W'(name_mask(3, NAME_BYTES));
      cmd_rec_q.phone <= in_i.phone;
    end
    if (load_out) begin
      out_status_q <= out_status_d;
      out_rec_q    <= out_rec_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_key   = out_rec_q.key;
  assign out_o.out_name0 = out_rec_q.name0;
  assign out_o.out_name1 = out_rec_q.name1;
  assign out_o.out_name2 = out_rec_q.name2;
  assign out_o.out_name3 = out_rec_q.name3;
  assign out_o.out_phone = out_rec_q.phone;
  assign out_o.last      = out_last_q;

  `SRT_ASSERT_SAME(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH), "record count above depth")
  `SRT_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, cell_op == CELL_INS, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the count")
  `SRT_ASSERT_SAME(a_delete_found, clk_i, rst_ni, cell_op == CELL_DEL, found && (count_q != '0), "delete shift without a match")
  `SRT_ASSERT_SAME(a_dump_index, clk_i, rst_ni, (state_q == ST_DUMP) && (count_q != '0), dump_cnt_q < count_q, "dump index past the last record")
  `SRT_ASSERT_NEXT(a_unused_kind, clk_i, rst_ni, in_fire && !(in_i.kind == KIND_INSERT || in_i.kind == KIND_DELETE || in_i.kind == KIND_DUMP), state_q == ST_IDLE, "unused request kind started work")

endmodule

>>> verif/tb_sorted_record_table.sv
// Self-checking testbench of the sorted record table with a scoreboard that tracks the table.
`timescale 1ns / 1ps

module tb_sorted_record_table;
  import srt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 20;

  // The kind field has one code that the table does not use.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    rec_t              rec;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    rec_t                rec;
    logic                last;
  } result_t;

  class record_table_scoreboard;
    rec_t        entries[$];
    result_t     pending[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      errors       = 0;
      results_seen = 0;
    endfunction

    function result_t bare_status(logic [STATUS_W-1:0] status);
      result_t r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
    endfunction

    function string describe(result_t r);
      return $sformatf("status=%0d key=%0d name=%h_%h_%h_%h phone=%h last=%b",
                       r.status, $signed(r.rec.key), r.rec.name3, r.rec.name2,
                       r.rec.name1, r.rec.name0, r.rec.phone, r.last);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] ERROR: %s", $time, msg);
      end
    endfunction

    // Applies one accepted request to the tracked table and queues its results.
    // All 25 name bytes fit the name fields exactly, so nothing is masked.
    function void note_request(request_t req);
      int unsigned pos;
      result_t     r;
      pos = 0;
      case (req.kind)
        KIND_INSERT: begin
          if (entries.size() >= TABLE_DEPTH) begin
            pending.push_back(bare_status(STATUS_FULL));
          end else begin
            // Records with an equal key stay ahead of the new one.
            while (pos < entries.size() &&
                   $signed(entries[pos].key) <= $signed(req.rec.key)) begin
              pos++;
            end
            entries.insert(pos, req.rec);
            pending.push_back(bare_status(STATUS_DONE));
          end
        end
        KIND_DELETE: begin
          while (pos < entries.size() && entries[pos].key != req.rec.key) begin
            pos++;
          end
          if (pos >= entries.size()) begin
            pending.push_back(bare_status(STATUS_NOT_FOUND));
          end else begin
            entries.delete(pos);
            pending.push_back(bare_status(STATUS_DONE));
          end
        end
        KIND_DUMP: begin
          if (entries.size() == 0) begin
            pending.push_back(bare_status(STATUS_EMPTY));
          end else begin
            foreach (entries[i]) begin
              r.status = STATUS_ENTRY;
              r.rec    = entries[i];
              r.last   = (i == entries.size() - 1);
              pending.push_back(r);
            end
          end
        end
        default: begin
          // The unused kind is dropped without a result.
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        flag_error($sformatf("result with nothing expected: %s", describe(got)));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.rec.key !== want.rec.key ||
          got.rec.name0 !== want.rec.name0 || got.rec.name1 !== want.rec.name1 ||
          got.rec.name2 !== want.rec.name2 || got.rec.name3 !== want.rec.name3 ||
          got.rec.phone !== want.rec.phone || got.last !== want.last) begin
        flag_error($sformatf("result mismatch\n  expected %s\n  actual   %s",
                             describe(want), describe(got)));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  srt_in_if  in_bus ();
  srt_out_if out_bus ();

  sorted_record_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  record_table_scoreboard sb = new();

  bit          send_calm;
  bit          recv_calm;
  int unsigned items_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(0, 9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3, 4, 5: return KEY_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_t random_rec(logic signed [KEY_W-1:0] key);
    rec_t r;
    r.name0 = {$urandom, $urandom};
    r.name1 = {$urandom, $urandom};
    r.name2 = {$urandom, $urandom};
    r.name3 = NAME3_W'($urandom);
    r.phone = PHONE_W'($urandom);
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      default: begin
      end
    endcase
    r.key = key;
    return r;
  endfunction

  // Deletes mostly hit a stored key so that the table really shrinks.
  function automatic request_t random_req(int unsigned insert_pct, int unsigned delete_pct);
    request_t                req;
    int unsigned             roll;
    logic signed [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    key  = random_key();
    if (roll < 3) begin
      req.kind = KIND_UNUSED;
    end else if (roll < 3 + insert_pct) begin
      req.kind = KIND_INSERT;
    end else if (roll < 3 + insert_pct + delete_pct) begin
      req.kind = KIND_DELETE;
      if (sb.entries.size() != 0 && $urandom_range(0, 99) < 85) begin
        key = sb.entries[$urandom_range(0, sb.entries.size() - 1)].key;
      end
    end else begin
      req.kind = KIND_DUMP;
    end
    req.rec = random_rec(key);
    return req;
  endfunction

  task automatic send_req(request_t req);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    @(negedge clk_i);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= req.kind;
    in_bus.key        <= req.rec.key;
    in_bus.name_part0 <= req.rec.name0;
    in_bus.name_part1 <= req.rec.name1;
    in_bus.name_part2 <= req.rec.name2;
    in_bus.name_part3 <= req.rec.name3;
    in_bus.phone      <= req.rec.phone;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_request(req);
    if (req.kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_op(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] key);
    send_req('{kind: kind, rec: random_rec(key)});
  endtask

  // Holds the input idle until every queued result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    rec_t        r;
    int unsigned goal;
    int unsigned half;
    int unsigned insert_pct;
    int unsigned delete_pct;
    bit          paused;

    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = KIND_INSERT;
    in_bus.key        = '0;
    in_bus.name_part0 = '0;
    in_bus.name_part1 = '0;
    in_bus.name_part2 = '0;
    in_bus.name_part3 = '0;
    in_bus.phone      = '0;
    send_calm         = 1'b0;
    items_sent        = 0;
    paused            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, missing key and the unused kind.
    send_op(KIND_DUMP, 0);
    send_op(KIND_DELETE, 5);
    send_op(KIND_UNUSED, -1);
    r = '0;
    send_req('{kind: KIND_INSERT, rec: r});
    r     = '1;
    r.key = KEY_MAX;
    send_req('{kind: KIND_INSERT, rec: r});
    send_op(KIND_INSERT, KEY_MIN);
    send_op(KIND_INSERT, -1);
    // Two more zero keys must land behind the first one.
    send_op(KIND_INSERT, 0);
    send_op(KIND_INSERT, 0);
    send_op(KIND_DUMP, 0);
    send_op(KIND_DELETE, 0);
    send_op(KIND_DELETE, 12345);
    r = '1;
    send_req('{kind: KIND_UNUSED, rec: r});
    send_op(KIND_DELETE, KEY_MAX);
    send_op(KIND_DELETE, KEY_MIN);
    send_op(KIND_DUMP, 0);
    send_op(KIND_DELETE, -1);
    send_op(KIND_DELETE, 0);
    send_op(KIND_DELETE, 0);
    send_op(KIND_DELETE, 0);
    send_op(KIND_DUMP, 0);
    wait_drained();

    goal = items_sent + RANDOM_ITEMS;
    half = items_sent + RANDOM_ITEMS / 2;

    // Fill the table to capacity, overflow it and read it back whole.
    while (sb.entries.size() < TABLE_DEPTH) send_op(KIND_INSERT, random_key());
    send_op(KIND_INSERT, random_key());
    send_op(KIND_INSERT, random_key());
    send_op(KIND_DUMP, 0);

    while (items_sent < goal) begin
      case ($urandom_range(0, 2))
        0: begin
          insert_pct = 75;
          delete_pct = 12;
        end
        1: begin
          insert_pct = 12;
          delete_pct = 70;
        end
        default: begin
          insert_pct = 40;
          delete_pct = 40;
        end
      endcase
      repeat ($urandom_range(15, 45)) send_req(random_req(insert_pct, delete_pct));
      if (!paused && items_sent >= half) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    result_t     got;
    out_bus.ready = 1'b0;
    recv_calm     = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      // Two long stalls back up the table while requests keep coming.
      if (sb.results_seen == 40 || sb.results_seen == 600) begin
        gap = LONG_HOLD;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 3);
      end
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      @(negedge clk_i);
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      got.status    = out_bus.status;
      got.rec.key   = out_bus.out_key;
      got.rec.name0 = out_bus.out_name0;
      got.rec.name1 = out_bus.out_name1;
      got.rec.name2 = out_bus.out_name2;
      got.rec.name3 = out_bus.out_name3;
      got.rec.phone = out_bus.out_phone;
      got.last      = out_bus.last;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
